/* rtl/core/pixel_color_adjust_macros.svh */
// Assertion macros for the pixel color adjust block.
// Used by pixel_color_adjust.sv; the bodies are empty when SYNTHESIS is defined.
`ifndef PIXEL_COLOR_ADJUST_MACROS_SVH
`define PIXEL_COLOR_ADJUST_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, clocked on clk, off during rst.
`define PCA_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pixel_color_adjust: implication check failed");

// Next-cycle implication, clocked on clk, off during rst.
`define PCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pixel_color_adjust: next-cycle check failed");

`else

`define PCA_ASSERT_IMPLY(label, ante, cons)
`define PCA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/core/pca_pkg.sv */
// Package for pixel_color_adjust: register indexes, mode codes and datapath helpers.
// No dependencies.
`timescale 1ns / 1ps

package pca_pkg;

  localparam int NUM_CH     = 3;   // red, green, blue
  localparam int CFG_W      = 16;  // widest register (contrast_gain)
  localparam int DIV_STEPS  = 4;   // quotient bits resolved per divider stage

  typedef logic [7:0]       chan_t;
  typedef logic [2:0]       reg_idx_t;
  typedef logic [CFG_W-1:0] cfg_data_t;
  typedef logic [2:0]       mode_t;

  // Register indexes
  localparam reg_idx_t REG_MODE       = 3'd0;
  localparam reg_idx_t REG_BRIGHTNESS = 3'd1;
  localparam reg_idx_t REG_CONTRAST   = 3'd2;
  localparam reg_idx_t REG_IN_LOW     = 3'd3;
  localparam reg_idx_t REG_IN_HIGH    = 3'd4;
  localparam reg_idx_t REG_OUT_LOW    = 3'd5;
  localparam reg_idx_t REG_OUT_HIGH   = 3'd6;

  // Mode codes; 6 and 7 behave as pass
  localparam mode_t MODE_PASS       = 3'd0;
  localparam mode_t MODE_INVERT     = 3'd1;
  localparam mode_t MODE_SEPIA      = 3'd2;
  localparam mode_t MODE_BRIGHTNESS = 3'd3;
  localparam mode_t MODE_CONTRAST   = 3'd4;
  localparam mode_t MODE_LEVELS     = 3'd5;

  localparam logic [15:0] CONTRAST_GAIN_ONE = 16'd256;  // 1.0 in Q8.8

  // Sepia weights, Q0.10; row = output channel, col = input channel
  function automatic logic [9:0] sepia_coef(input int row, input int col);
    logic [9:0] k;
    case (row * NUM_CH + col)
      0:       k = 10'd402;
      1:       k = 10'd787;
      2:       k = 10'd194;
      3:       k = 10'd357;
      4:       k = 10'd702;
      5:       k = 10'd172;
      6:       k = 10'd279;
      7:       k = 10'd547;
      8:       k = 10'd134;
      default: k = 10'd0;
    endcase
    return k;
  endfunction

  // One restoring-division step: shift in a numerator bit, subtract span if it fits.
  // Partial remainder is always below span, so it stays 8 bits.
  // Returns {quotient bit, new remainder}.
  function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nbit,
                                          input logic [7:0] span);
    logic [8:0] trial;
    logic [8:0] diff;
    trial = {rem, nbit};
    diff  = trial - {1'b0, span};
    if (!diff[8]) begin
      return {1'b1, diff[7:0]};
    end else begin
      return {1'b0, trial[7:0]};
    end
  endfunction

endpackage

/* rtl/core/pixel_color_adjust.sv */
// Top level of the pixel color adjust block: config registers and five-stage datapath.
// Depends on pca_pkg and pixel_color_adjust_macros.svh.
`timescale 1ns / 1ps
`include "pixel_color_adjust_macros.svh"

// pixel_color_adjust: one RGBA pixel in, one adjusted pixel out, alpha untouched.
// The mode register picks pass, invert, sepia, brightness, contrast or levels
// (codes 6 and 7 pass the pixel through). Throughput is one pixel per clock
// when nothing stalls. The pipeline depth is set by the levels path, whose
// d*(out_high-out_low)/span divide runs as an 8-bit restoring divider split
// over two pipeline stages. Each stage holds its own valid bit and moves
// forward whenever the stage ahead is empty or moving, so bubbles are squeezed
// out and a stalled result does not block intake until all five stages are
// full. pixel_stall is combinational from result_stall through that ready
// chain. Configuration registers are read live by every stage: write them only
// while no transaction is in flight. Register writes with an index above 6 are
// dropped. There is no state between pixels.
module pixel_color_adjust (
  input  logic                clk,
  input  logic                rst,
  // configuration write port
  input  logic                cfg_write,
  input  pca_pkg::reg_idx_t   cfg_index,
  input  pca_pkg::cfg_data_t  cfg_data,
  // pixel input channel
  input  logic                pixel_valid,
  output logic                pixel_stall,
  input  logic [7:0]          red_in,
  input  logic [7:0]          green_in,
  input  logic [7:0]          blue_in,
  input  logic [7:0]          alpha_in,
  // result output channel
  output logic                result_valid,
  input  logic                result_stall,
  output logic [7:0]          red_out,
  output logic [7:0]          green_out,
  output logic [7:0]          blue_out,
  output logic [7:0]          alpha_out
);

  import pca_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  mode_t              mode;
  logic signed [8:0]  brightness_delta;
  logic [15:0]        contrast_gain;
  chan_t              in_low;
  chan_t              in_high;
  chan_t              out_low;
  chan_t              out_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_PASS;
      brightness_delta <= '0;
      contrast_gain    <= CONTRAST_GAIN_ONE;
      in_low           <= 8'd0;
      in_high          <= 8'd255;
      out_low          <= 8'd0;
      out_high         <= 8'd255;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE:       mode             <= cfg_data[2:0];
        REG_BRIGHTNESS: brightness_delta <= $signed(cfg_data[8:0]);
        REG_CONTRAST:   contrast_gain    <= cfg_data[15:0];
        REG_IN_LOW:     in_low           <= cfg_data[7:0];
        REG_IN_HIGH:    in_high          <= cfg_data[7:0];
        REG_OUT_LOW:    out_low          <= cfg_data[7:0];
        REG_OUT_HIGH:   out_high         <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Levels constants derived from the registers (the user must keep them static while busy; not enforced here)
  chan_t       lev_span;    // max(1, in_high - in_low)
  logic [8:0]  lev_delta;   // out_high - out_low, two's complement
  logic        lev_neg;     // falling ramp
  chan_t       lev_mag;     // |out_high - out_low|

  always_comb begin
    lev_span  = (in_high > in_low) ? (in_high - in_low) : 8'd1;
    lev_delta = {1'b0, out_high} - {1'b0, out_low};
    lev_neg   = lev_delta[8];
    lev_mag   = lev_neg ? 8'((~lev_delta) + 9'd1) : lev_delta[7:0];
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its item moves on
  // ---------------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

  assign s5_ready = !s5_valid || !result_stall;
  assign s4_ready = !s4_valid || s5_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;

  assign pixel_stall = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= pixel_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (s4_ready) s4_valid <= s3_valid;
      if (s5_ready) s5_valid <= s4_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: per-channel products, simple ops, levels offset clamp
  // ---------------------------------------------------------------------------
  chan_t pix [NUM_CH];
  assign pix[0] = red_in;
  assign pix[1] = green_in;
  assign pix[2] = blue_in;

  chan_t              s1_simple_next [NUM_CH];
  logic [17:0]        s1_sep_next    [NUM_CH][NUM_CH];
  logic signed [25:0] s1_con_next    [NUM_CH];
  chan_t              s1_d_next      [NUM_CH];

  logic signed [9:0]  bright_sum [NUM_CH];
  logic signed [8:0]  con_diff   [NUM_CH];
  logic signed [8:0]  lev_diff   [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      // brightness, saturated
      bright_sum[i] = $signed({2'b00, pix[i]}) + $signed({brightness_delta[8], brightness_delta});
      case (mode)
        MODE_INVERT: s1_simple_next[i] = 8'd255 - pix[i];
        MODE_BRIGHTNESS: begin
          if (bright_sum[i][9]) begin
            s1_simple_next[i] = 8'd0;
          end else if (bright_sum[i][8]) begin
            s1_simple_next[i] = 8'd255;
          end else begin
            s1_simple_next[i] = bright_sum[i][7:0];
          end
        end
        default: s1_simple_next[i] = pix[i];
      endcase

      // sepia: output row i takes k[i][j] * input j
      for (int j = 0; j < NUM_CH; j++) begin
        s1_sep_next[i][j] = 18'(pix[j]) * 18'(sepia_coef(i, j));
      end

      // contrast: gain * (c - 128)
      con_diff[i]    = $signed({1'b0, pix[i]}) - 9'sd128;
      s1_con_next[i] = $signed({1'b0, contrast_gain}) * con_diff[i];

      // levels: d = clamp(c - in_low, 0, span)
      lev_diff[i] = $signed({1'b0, pix[i]}) - $signed({1'b0, in_low});
      if (lev_diff[i][8]) begin
        s1_d_next[i] = 8'd0;
      end else if (lev_diff[i][7:0] > lev_span) begin
        s1_d_next[i] = lev_span;
      end else begin
        s1_d_next[i] = lev_diff[i][7:0];
      end
    end
  end

  chan_t              s1_alpha;
  chan_t              s1_simple [NUM_CH];
  logic [17:0]        s1_sep    [NUM_CH][NUM_CH];
  logic signed [25:0] s1_con    [NUM_CH];
  chan_t              s1_d      [NUM_CH];

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_alpha  <= alpha_in;
      s1_simple <= s1_simple_next;
      s1_sep    <= s1_sep_next;
      s1_con    <= s1_con_next;
      s1_d      <= s1_d_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: sepia sum and clamp, contrast floor and clamp, levels product
  // ---------------------------------------------------------------------------
  chan_t              s2_res_next [NUM_CH];
  logic [15:0]        s2_num_next [NUM_CH];
  logic [19:0]        sep_sum     [NUM_CH];
  chan_t              sep_val     [NUM_CH];
  logic signed [25:0] con_t       [NUM_CH];
  chan_t              con_val     [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      sep_sum[i] = 20'(s1_sep[i][0]) + 20'(s1_sep[i][1]) + 20'(s1_sep[i][2]);
      sep_val[i] = (|sep_sum[i][19:18]) ? 8'd255 : sep_sum[i][17:10];

      // t = gain*(c-128) + 128*256; floor(t/256) clamped, negative t gives 0
      con_t[i] = s1_con[i] + 26'sd32768;
      if (con_t[i][25]) begin
        con_val[i] = 8'd0;
      end else if (|con_t[i][24:16]) begin
        con_val[i] = 8'd255;
      end else begin
        con_val[i] = con_t[i][15:8];
      end

      case (mode)
        MODE_SEPIA:    s2_res_next[i] = sep_val[i];
        MODE_CONTRAST: s2_res_next[i] = con_val[i];
        default:       s2_res_next[i] = s1_simple[i];
      endcase

      s2_num_next[i] = 16'(s1_d[i]) * 16'(lev_mag);
    end
  end

  chan_t       s2_alpha;
  chan_t       s2_res [NUM_CH];
  logic [15:0] s2_num [NUM_CH];

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_alpha <= s1_alpha;
      s2_res   <= s2_res_next;
      s2_num   <= s2_num_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: quotient bits 7..4. Since d <= span the quotient fits 8 bits,
  // so the upper numerator byte is already a valid partial remainder.
  // ---------------------------------------------------------------------------
  chan_t      s3_rem_next [NUM_CH];
  logic [3:0] s3_qhi_next [NUM_CH];
  logic [8:0] div3_step   [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      s3_rem_next[i] = s2_num[i][15:8];
      s3_qhi_next[i] = '0;
      div3_step[i]   = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
        div3_step[i]   = div_step(s3_rem_next[i], s2_num[i][7-k], lev_span);
        s3_qhi_next[i] = {s3_qhi_next[i][2:0], div3_step[i][8]};
        s3_rem_next[i] = div3_step[i][7:0];
      end
    end
  end

  chan_t      s3_alpha;
  chan_t      s3_res [NUM_CH];
  chan_t      s3_rem [NUM_CH];
  logic [3:0] s3_qhi [NUM_CH];
  logic [3:0] s3_nlo [NUM_CH];

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_alpha <= s2_alpha;
      s3_res   <= s2_res;
      s3_rem   <= s3_rem_next;
      s3_qhi   <= s3_qhi_next;
      for (int i = 0; i < NUM_CH; i++) begin
        s3_nlo[i] <= s2_num[i][3:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: quotient bits 3..0
  // ---------------------------------------------------------------------------
  chan_t      s4_q_next [NUM_CH];
  chan_t      div4_rem  [NUM_CH];
  logic [8:0] div4_step [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      div4_rem[i]  = s3_rem[i];
      s4_q_next[i] = {4'd0, s3_qhi[i]};
      div4_step[i] = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
        div4_step[i] = div_step(div4_rem[i], s3_nlo[i][3-k], lev_span);
        s4_q_next[i] = {s4_q_next[i][6:0], div4_step[i][8]};
        div4_rem[i]  = div4_step[i][7:0];
      end
    end
  end

  chan_t s4_alpha;
  chan_t s4_res [NUM_CH];
  chan_t s4_q   [NUM_CH];

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      s4_alpha <= s3_alpha;
      s4_res   <= s3_res;
      s4_q     <= s4_q_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: levels offset and final select into the output register
  // ---------------------------------------------------------------------------
  chan_t      s5_rgb_next [NUM_CH];
  logic [9:0] lev_v       [NUM_CH];
  chan_t      lev_val     [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      if (lev_neg) begin
        lev_v[i] = {2'b00, out_low} - {2'b00, s4_q[i]};
      end else begin
        lev_v[i] = {2'b00, out_low} + {2'b00, s4_q[i]};
      end
      if (lev_v[i][9]) begin
        lev_val[i] = 8'd0;
      end else if (lev_v[i][8]) begin
        lev_val[i] = 8'd255;
      end else begin
        lev_val[i] = lev_v[i][7:0];
      end
      s5_rgb_next[i] = (mode == MODE_LEVELS) ? lev_val[i] : s4_res[i];
    end
  end

  chan_t s5_alpha;
  chan_t s5_rgb [NUM_CH];

  always_ff @(posedge clk) begin
    if (s5_ready) begin
      s5_alpha <= s4_alpha;
      s5_rgb   <= s5_rgb_next;
    end
  end

  assign result_valid = s5_valid;
  assign red_out      = s5_rgb[0];
  assign green_out    = s5_rgb[1];
  assign blue_out     = s5_rgb[2];
  assign alpha_out    = s5_alpha;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Intake only closes when every stage holds a transaction and the output waits.
  `PCA_ASSERT_IMPLY(a_stall_only_when_full, pixel_stall,
    s1_valid && s2_valid && s3_valid && s4_valid && s5_valid && result_stall)

  // A blocked stage keeps its transaction.
  `PCA_ASSERT_NEXT(a_blocked_stage_holds, s4_valid && !s5_ready, s4_valid)

  for (genvar gi = 0; gi < NUM_CH; gi++) begin : g_chk
    // Divider partial remainder stays below the span.
    `PCA_ASSERT_IMPLY(a_rem_below_span, s3_valid, s3_rem[gi] < lev_span)
    // Quotient never exceeds the output ramp height.
    `PCA_ASSERT_IMPLY(a_quot_in_ramp, s4_valid, s4_q[gi] <= lev_mag)
  end

endmodule
